// ===== src/pps_pkg.sv =====
// ============================================================================
// pps_pkg
// Shared types and constants for the polygon plane splitter.
// ============================================================================
package pps_pkg;

   localparam int MAX_VERTS_DEF   = 16;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int FRAC_W          = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_TOL = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTR     = 3'd7;

   // Reset values of the registers that do not reset to zero.
   localparam logic signed [31:0] NORMAL_X_RST = 32'sd65536;
   localparam logic [30:0]        SIDE_TOL_RST = 31'd66;

   // Number of vertex attributes held in the store.
   localparam int NUM_ATTR = 8;
   localparam int ATTR_LERP = 5;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic               last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_u;
      logic signed [31:0] out_v;
      logic signed [31:0] out_nx;
      logic signed [31:0] out_ny;
      logic signed [31:0] out_nz;
      logic               to_front;
      logic               to_back;
      logic               last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RD_PREV,
      ST_DIST_PREV,
      ST_RD_CUR,
      ST_DIST_CUR,
      ST_CLASSIFY,
      ST_DIVIDE,
      ST_LERP,
      ST_EMIT_X,
      ST_EMIT_V,
      ST_NEXT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store_wr;      // write the accepted item into the store
      logic rd_prev;       // read store at the previous index
      logic rd_cur;        // read store at the current index
      logic dist_start;    // start a distance evaluation
      logic save_prev;     // latch distance/vertex of A
      logic div_start;     // start the crossing fraction divide
      logic lerp_start;    // start the interpolation
      logic load_x;        // load crossing result into output register
      logic load_v;        // load vertex result into output register
      logic last_flag;     // mark the loaded result as last of run
      logic shift_prev;    // current becomes previous
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic dist_done;
      logic div_done;
      logic lerp_done;
      logic crossing;
   } sts_type;

endpackage

// ===== src/polygon_plane_split.sv =====
// ============================================================================
// polygon_plane_split
// Splits one polygon against a configured plane into front and back lists.
// ============================================================================
// Vertices are taken one per cycle while loading; the item marked last starts
// the walk, during which input is stalled. The walk opens with a store read
// and a plane distance of the last vertex (the distance multiplies one axis
// per cycle). Each edge then takes a store read, a distance, classification,
// a result load and a step. A crossing edge adds a restoring divide, an
// interpolation and one more result load. A stalled result holds the walk.
module polygon_plane_split #(
   parameter int MAX_VERTS   = pps_pkg::MAX_VERTS_DEF,
   parameter int COORD_WIDTH = pps_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pps_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pps_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [pps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pps_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   pps_pkg::cmd_type cmd;
   pps_pkg::sts_type sts;
   logic [$clog2(MAX_VERTS)-1:0] wr_idx;
   logic [$clog2(MAX_VERTS)-1:0] rd_idx;

   pps_ctrl #(.MAX_VERTS(MAX_VERTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_last  (req_data.last_vertex),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .wr_idx    (wr_idx),
      .rd_idx    (rd_idx)
   );

   pps_datapath #(.MAX_VERTS(MAX_VERTS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .wr_idx      (wr_idx),
      .rd_idx      (rd_idx),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== src/pps_ram.sv =====
// ============================================================================
// pps_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module pps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pps_datapath.sv =====
// ============================================================================
// pps_datapath
// Vertex store, plane distance unit, serial divider and serial interpolator.
// ============================================================================
module pps_datapath #(
   parameter int MAX_VERTS   = pps_pkg::MAX_VERTS_DEF,
   parameter int COORD_WIDTH = pps_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pps_pkg::cmd_type              cmd,
   output pps_pkg::sts_type              sts,
   input  logic [$clog2(MAX_VERTS)-1:0]  wr_idx,
   input  logic [$clog2(MAX_VERTS)-1:0]  rd_idx,
   input  pps_pkg::req_type              req_data,
   input  logic                          csr_wr_en,
   input  logic [pps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pps_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output pps_pkg::rsp_type              rsp_data
);

   localparam int CW  = COORD_WIDTH;
   localparam int PW  = CW + 32;           // product width
   localparam int SW  = PW - 16 + 2;       // sum of three shifted products
   localparam int FW  = pps_pkg::FRAC_W;
   localparam int NA  = pps_pkg::NUM_ATTR;
   localparam int NAW = $clog2(NA);
   localparam int NL  = pps_pkg::ATTR_LERP;
   localparam int DW  = CW + 1;            // magnitude width of a distance
   localparam int DDW = CW + 2;            // magnitude width of dA - dB
   localparam int DIFFW = CW + 1;          // lerp difference width
   localparam int LPW = DIFFW + FW + 1;    // lerp product width
   localparam int DIV_CNT_W = $clog2(DW + FW + 1);
   localparam int LERP_CNT_W = $clog2(NL + 1);
   localparam int AX_CNT_W = 2;

   // ---------------------------------------------------------------------
   // Configuration registers.
   logic signed [31:0] nrm_ff [3];
   logic signed [31:0] org_ff [3];
   logic [30:0]        tol_ff;
   logic [1:0]         attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nrm_ff[0] <= pps_pkg::NORMAL_X_RST;
         nrm_ff[1] <= '0;
         nrm_ff[2] <= '0;
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         tol_ff    <= pps_pkg::SIDE_TOL_RST;
         attr_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            pps_pkg::CSR_NORMAL_X: nrm_ff[0] <= csr_wr_data;
            pps_pkg::CSR_NORMAL_Y: nrm_ff[1] <= csr_wr_data;
            pps_pkg::CSR_NORMAL_Z: nrm_ff[2] <= csr_wr_data;
            pps_pkg::CSR_ORIGIN_X: org_ff[0] <= csr_wr_data;
            pps_pkg::CSR_ORIGIN_Y: org_ff[1] <= csr_wr_data;
            pps_pkg::CSR_ORIGIN_Z: org_ff[2] <= csr_wr_data;
            pps_pkg::CSR_SIDE_TOL: tol_ff    <= csr_wr_data[30:0];
            pps_pkg::CSR_ATTR:     attr_ff   <= csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Vertex store: one RAM per attribute, truncated to the coordinate width.
   logic [CW-1:0] wr_word [NA];
   logic [CW-1:0] rd_word [NA];

   assign wr_word[0] = CW'(req_data.pos_x);
   assign wr_word[1] = CW'(req_data.pos_y);
   assign wr_word[2] = CW'(req_data.pos_z);
   assign wr_word[3] = CW'(req_data.tex_u);
   assign wr_word[4] = CW'(req_data.tex_v);
   assign wr_word[5] = CW'(req_data.norm_x);
   assign wr_word[6] = CW'(req_data.norm_y);
   assign wr_word[7] = CW'(req_data.norm_z);

   for (genvar g = 0; g < NA; g++) begin : g_store
      pps_ram #(.WIDTH(CW), .DEPTH(MAX_VERTS)) u_ram (
         .clock   (clock),
         .wr_en   (cmd.store_wr),
         .wr_addr (wr_idx),
         .wr_data (wr_word[g]),
         .rd_en   (cmd.rd_prev | cmd.rd_cur),
         .rd_addr (rd_idx),
         .rd_data (rd_word[g])
      );
   end

   // Current vertex B and previous vertex A attributes.
   logic signed [CW-1:0] vb_ff [NA];
   logic signed [CW-1:0] va_ff [NA];

   // ---------------------------------------------------------------------
   // Distance unit: one axis per cycle, one multiplier shared over axes.
   logic                  dist_busy_ff;
   logic [AX_CNT_W-1:0]   ax_ff;
   logic signed [SW-1:0]  acc_ff;
   logic signed [PW-1:0]  prod_ff;
   logic                  prod_vld_ff;
   logic signed [DW-1:0]  dist_ff;       // saturated to CW, kept one bit wider
   logic                  dist_done_ff;
   logic signed [CW:0]    diff_raw;
   logic signed [CW-1:0]  diff_sat;
   logic signed [CW-1:0]  sel_p;
   logic signed [CW-1:0]  sel_o;
   logic signed [SW-1:0]  acc_sum;
   logic signed [CW-1:0]  acc_sat;

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   always_comb begin
      sel_p = vb_ff[NAW'(ax_ff)];
      sel_o = CW'(org_ff[ax_ff]);
      diff_raw = (CW+1)'(sel_p) - (CW+1)'(sel_o);
      if (diff_raw > (CW+1)'(CMAX)) begin
         diff_sat = CMAX;
      end else if (diff_raw < (CW+1)'(CMIN)) begin
         diff_sat = CMIN;
      end else begin
         diff_sat = diff_raw[CW-1:0];
      end
      acc_sum = acc_ff + SW'(prod_ff >>> 16);
      if (acc_ff > SW'(CMAX)) begin
         acc_sat = CMAX;
      end else if (acc_ff < SW'(CMIN)) begin
         acc_sat = CMIN;
      end else begin
         acc_sat = acc_ff[CW-1:0];
      end
   end

   // Multiply one axis per cycle, accumulate in the following cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_busy_ff <= 1'b0;
         ax_ff        <= '0;
         prod_vld_ff  <= 1'b0;
         dist_done_ff <= 1'b0;
      end else begin
         dist_done_ff <= 1'b0;
         if (cmd.dist_start) begin
            dist_busy_ff <= 1'b1;
            ax_ff        <= '0;
            prod_vld_ff  <= 1'b0;
            acc_ff       <= '0;
         end else if (dist_busy_ff) begin
            if (prod_vld_ff) begin
               acc_ff <= acc_sum;
            end
            if (ax_ff != AX_CNT_W'(3)) begin
               prod_ff     <= PW'(nrm_ff[ax_ff]) * PW'(diff_sat);
               prod_vld_ff <= 1'b1;
               ax_ff       <= ax_ff + 1'b1;
            end else if (prod_vld_ff) begin
               prod_vld_ff <= 1'b0;
            end else begin
               dist_busy_ff <= 1'b0;
               dist_done_ff <= 1'b1;
               dist_ff      <= DW'(acc_sat);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Classification of B against A.
   logic signed [DW-1:0] sa_ff;
   logic signed [DW-1:0] tol_p;
   logic signed [DW-1:0] tol_n;
   logic                 bf;
   logic                 bb;
   logic                 af;
   logic                 ab;

   assign tol_p = DW'($signed({1'b0, tol_ff}));
   assign tol_n = -tol_p;
   assign bf = dist_ff > tol_p;
   assign bb = dist_ff < tol_n;
   assign af = sa_ff > tol_p;
   assign ab = sa_ff < tol_n;

   // Vertex registers follow the RAM reads.
   logic rd_prev_d_ff;
   logic rd_cur_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_prev_d_ff <= 1'b0;
         rd_cur_d_ff  <= 1'b0;
      end else begin
         rd_prev_d_ff <= cmd.rd_prev;
         rd_cur_d_ff  <= cmd.rd_cur;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         if (rd_prev_d_ff || rd_cur_d_ff) begin
            vb_ff[i] <= rd_word[i];
         end
         if (cmd.shift_prev || cmd.save_prev) begin
            va_ff[i] <= vb_ff[i];
         end
      end
      if (cmd.shift_prev || cmd.save_prev) begin
         sa_ff <= dist_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Crossing fraction: restoring divider, one quotient bit per cycle.
   logic [DW+FW-1:0]      num_ff;
   logic [DDW-1:0]        den_ff;
   logic [DDW:0]          rem_ff;
   logic [FW-1:0]         quo_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic                  div_busy_ff;
   logic                  div_done_ff;
   logic [DDW:0]          rem_sh;
   logic [DW-1:0]         na;
   logic signed [DDW-1:0] dd;

   assign na = sa_ff[DW-1] ? DW'(-sa_ff) : DW'(sa_ff);
   assign dd = DDW'(sa_ff) - DDW'(dist_ff);
   assign rem_sh = {rem_ff[DDW-1:0], num_ff[DW+FW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
      end else begin
         div_done_ff <= 1'b0;
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
            num_ff      <= {na, {FW{1'b0}}};
            den_ff      <= dd[DDW-1] ? DDW'(-dd) : DDW'(dd);
            rem_ff      <= '0;
            quo_ff      <= '0;
            div_cnt_ff  <= '0;
         end else if (div_busy_ff) begin
            num_ff <= {num_ff[DW+FW-2:0], 1'b0};
            if (rem_sh >= (DDW+1)'(den_ff)) begin
               rem_ff <= rem_sh - (DDW+1)'(den_ff);
               quo_ff <= {quo_ff[FW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[FW-2:0], 1'b0};
            end
            if (div_cnt_ff == DIV_CNT_W'(DW + FW - 1)) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
            end
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Interpolation: one attribute per step, multiply then add.
   logic [LERP_CNT_W-1:0]   lp_cnt_ff;
   logic                    lp_busy_ff;
   logic                    lp_ph_ff;
   logic                    lp_done_ff;
   logic signed [LPW-1:0]   lp_prod_ff;
   logic signed [CW-1:0]    cx_ff [NL];
   logic signed [DIFFW-1:0] lp_diff;
   logic signed [LPW-1:0]   lp_shift;

   assign lp_diff  = DIFFW'(vb_ff[lp_cnt_ff]) - DIFFW'(va_ff[lp_cnt_ff]);
   assign lp_shift = lp_prod_ff >>> FW;

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_busy_ff <= 1'b0;
         lp_done_ff <= 1'b0;
         lp_ph_ff   <= 1'b0;
      end else begin
         lp_done_ff <= 1'b0;
         if (cmd.lerp_start) begin
            lp_busy_ff <= 1'b1;
            lp_cnt_ff  <= '0;
            lp_ph_ff   <= 1'b0;
         end else if (lp_busy_ff) begin
            if (!lp_ph_ff) begin
               lp_prod_ff <= LPW'(lp_diff) * $signed({1'b0, quo_ff});
               lp_ph_ff   <= 1'b1;
            end else begin
               cx_ff[lp_cnt_ff] <= va_ff[lp_cnt_ff] + lp_shift[CW-1:0];
               lp_ph_ff <= 1'b0;
               if (lp_cnt_ff == LERP_CNT_W'(NL - 1)) begin
                  lp_busy_ff <= 1'b0;
                  lp_done_ff <= 1'b1;
               end
               lp_cnt_ff <= lp_cnt_ff + 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register.
   pps_pkg::rsp_type rsp_ff;
   logic signed [CW-1:0] ov [NA];

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         ov[i] = vb_ff[i];
      end
      if (cmd.load_x) begin
         for (int i = 0; i < NL; i++) begin
            ov[i] = cx_ff[i];
         end
      end
      if (!attr_ff[0]) begin
         ov[3] = '0;
         ov[4] = '0;
      end
      if (!attr_ff[1]) begin
         ov[5] = '0;
         ov[6] = '0;
         ov[7] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_x || cmd.load_v) begin
         rsp_ff.out_x       <= 32'(ov[0]);
         rsp_ff.out_y       <= 32'(ov[1]);
         rsp_ff.out_z       <= 32'(ov[2]);
         rsp_ff.out_u       <= 32'(ov[3]);
         rsp_ff.out_v       <= 32'(ov[4]);
         rsp_ff.out_nx      <= 32'(ov[5]);
         rsp_ff.out_ny      <= 32'(ov[6]);
         rsp_ff.out_nz      <= 32'(ov[7]);
         rsp_ff.to_front    <= cmd.load_x | bf | !bb;
         rsp_ff.to_back     <= cmd.load_x | bb | !bf;
         rsp_ff.last_of_run <= cmd.last_flag;
      end
   end

   assign rsp_data = rsp_ff;

   assign sts.dist_done = dist_done_ff;
   assign sts.div_done  = div_done_ff;
   assign sts.lerp_done = lp_done_ff;
   assign sts.crossing  = (bf && ab) || (bb && af);

endmodule

// ===== src/pps_ctrl.sv =====
// ============================================================================
// pps_ctrl
// Sequencer: loads vertices, then walks the polygon's edges.
// ============================================================================
module pps_ctrl #(
   parameter int MAX_VERTS = pps_pkg::MAX_VERTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pps_pkg::cmd_type              cmd,
   input  pps_pkg::sts_type              sts,
   output logic [$clog2(MAX_VERTS)-1:0]  wr_idx,
   output logic [$clog2(MAX_VERTS)-1:0]  rd_idx
);

   localparam int AW = $clog2(MAX_VERTS);
   localparam int CNTW = $clog2(MAX_VERTS + 1);

   pps_pkg::state_type state_ff, state_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [AW-1:0]   cur_ff, cur_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_acc;
   logic            is_last_edge;
   logic            rd_d_ff;

   assign req_acc = req_valid && !req_stall;
   assign wr_idx  = count_ff[AW-1:0];
   assign is_last_edge = (CNTW'(cur_ff) == count_ff - 1'b1);
   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != pps_pkg::ST_LOAD);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pps_pkg::ST_LOAD: begin
            if (req_acc && req_last) begin
               if (count_ff != '0 || count_ff < CNTW'(MAX_VERTS)) begin
                  state_in = pps_pkg::ST_RD_PREV;
               end
            end
         end
         pps_pkg::ST_RD_PREV:   state_in = pps_pkg::ST_DIST_PREV;
         pps_pkg::ST_DIST_PREV: begin
            if (sts.dist_done) begin
               state_in = pps_pkg::ST_RD_CUR;
            end
         end
         pps_pkg::ST_RD_CUR:    state_in = pps_pkg::ST_DIST_CUR;
         pps_pkg::ST_DIST_CUR: begin
            if (sts.dist_done) begin
               state_in = pps_pkg::ST_CLASSIFY;
            end
         end
         pps_pkg::ST_CLASSIFY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = sts.crossing ? pps_pkg::ST_DIVIDE : pps_pkg::ST_EMIT_V;
            end
         end
         pps_pkg::ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = pps_pkg::ST_LERP;
            end
         end
         pps_pkg::ST_LERP: begin
            if (sts.lerp_done) begin
               state_in = pps_pkg::ST_EMIT_X;
            end
         end
         pps_pkg::ST_EMIT_X: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = pps_pkg::ST_EMIT_V;
            end
         end
         pps_pkg::ST_EMIT_V: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = pps_pkg::ST_NEXT;
            end
         end
         pps_pkg::ST_NEXT: begin
            state_in = is_last_edge ? pps_pkg::ST_LOAD : pps_pkg::ST_RD_CUR;
         end
         default: state_in = pps_pkg::ST_LOAD;
      endcase
   end

   // Outputs and counters.
   always_comb begin
      cmd          = '0;
      count_in     = count_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_idx       = cur_ff;
      case (state_ff)
         pps_pkg::ST_LOAD: begin
            if (req_acc) begin
               if (count_ff < CNTW'(MAX_VERTS)) begin
                  cmd.store_wr = 1'b1;
                  count_in     = count_ff + 1'b1;
               end
               cur_in = '0;
               if (req_last && count_ff == '0 && !(count_ff < CNTW'(MAX_VERTS))) begin
                  count_in = '0;
               end
            end
         end
         pps_pkg::ST_RD_PREV: begin
            rd_idx      = AW'(count_ff - 1'b1);
            cmd.rd_prev = 1'b1;
         end
         pps_pkg::ST_DIST_PREV: begin
            if (sts.dist_done) begin
               cmd.save_prev = 1'b1;
            end
         end
         pps_pkg::ST_RD_CUR: begin
            cmd.rd_cur = 1'b1;
         end
         pps_pkg::ST_CLASSIFY: begin
            if (state_in == pps_pkg::ST_DIVIDE) begin
               cmd.div_start = 1'b1;
            end
         end
         pps_pkg::ST_DIVIDE: begin
            if (sts.div_done) begin
               cmd.lerp_start = 1'b1;
            end
         end
         pps_pkg::ST_EMIT_X: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_x   = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         pps_pkg::ST_EMIT_V: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_v    = 1'b1;
               cmd.last_flag = is_last_edge;
               rsp_valid_in  = 1'b1;
            end
         end
         pps_pkg::ST_NEXT: begin
            cmd.shift_prev = 1'b1;
            cur_in = cur_ff + 1'b1;
            if (is_last_edge) begin
               count_in = '0;
            end
         end
         default: ;
      endcase
      // A distance evaluation starts in the cycle after each store read.
      cmd.dist_start = rd_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pps_pkg::ST_LOAD;
         count_ff     <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_d_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_d_ff      <= cmd.rd_prev | cmd.rd_cur;
      end
   end

   // The store never holds more vertices than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_VERTS))
      else $error("vertex count exceeds store depth");

   // No input is taken while a polygon is being walked.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != pps_pkg::ST_LOAD) |-> !cmd.store_wr)
      else $error("store written during walk");

   // A result marked last is followed by the step that ends the walk.
   assert property (@(posedge clock) disable iff (reset)
      cmd.last_flag |=> (state_ff == pps_pkg::ST_NEXT))
      else $error("last result not followed by end of walk");

endmodule

// ===== sim/tb_polygon_plane_split.sv =====
// ============================================================================
// tb_polygon_plane_split
// Self-checking testbench for the polygon plane splitter.
// ============================================================================
// Polygons are sent vertex by vertex through the request channel. A software
// copy of the splitter computes the expected emitted vertices for every
// accepted item. The monitor compares each accepted result field by field.
// Runs cover several plane settings and several sender and receiver idling
// phases.
`timescale 1ns / 100ps

module tb_polygon_plane_split;

   localparam int DEPTH = pps_pkg::MAX_VERTS_DEF;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   pps_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   pps_pkg::rsp_type rsp_data;
   logic             csr_wr_en;
   logic [pps_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pps_pkg::CSR_DATA_W-1:0] csr_wr_data;

   polygon_plane_split uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // Plane settings and vertex store of the software copy.
   longint plane_n [3];
   longint plane_o [3];
   longint side_tol;
   logic [1:0] attr_mode;
   longint vstore [DEPTH][8];
   int     vert_count = 0;

   pps_pkg::req_type vertex_queue [$];
   pps_pkg::rsp_type split_expected [$];
   int      error_count = 0;
   int      items_sent = 0;
   int      results_seen = 0;
   int      send_idle_pct;
   int      recv_stall_pct;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Saturate to the coordinate width.
   function automatic longint sat_coord(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // Signed floor division by 65536, done as an arithmetic shift.
   function automatic longint floor_q16(longint x);
      return x >>> 16;
   endfunction

   function automatic longint plane_distance(int i);
      longint d;
      longint s;
      s = 0;
      for (int a = 0; a < 3; a++) begin
         d = sat_coord(vstore[i][a] - plane_o[a]);
         s += floor_q16(plane_n[a] * d);
      end
      return sat_coord(s);
   endfunction

   function automatic pps_pkg::rsp_type make_vertex(longint v [8], bit fr, bit bk);
      pps_pkg::rsp_type r;
      r.out_x  = v[0][31:0];
      r.out_y  = v[1][31:0];
      r.out_z  = v[2][31:0];
      r.out_u  = attr_mode[0] ? v[3][31:0] : '0;
      r.out_v  = attr_mode[0] ? v[4][31:0] : '0;
      r.out_nx = attr_mode[1] ? v[5][31:0] : '0;
      r.out_ny = attr_mode[1] ? v[6][31:0] : '0;
      r.out_nz = attr_mode[1] ? v[7][31:0] : '0;
      r.to_front = fr;
      r.to_back  = bk;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // Stores the vertex and, on the last one, queues the split vertices.
   task automatic predict_split(pps_pkg::req_type it);
      int n;
      int prev;
      longint da, db, na, nd, fr;
      longint av [8];
      longint bv [8];
      longint cv [8];
      bit bf, bb;
      if (vert_count < DEPTH) begin
         vstore[vert_count][0] = it.pos_x;
         vstore[vert_count][1] = it.pos_y;
         vstore[vert_count][2] = it.pos_z;
         vstore[vert_count][3] = it.tex_u;
         vstore[vert_count][4] = it.tex_v;
         vstore[vert_count][5] = it.norm_x;
         vstore[vert_count][6] = it.norm_y;
         vstore[vert_count][7] = it.norm_z;
         vert_count++;
      end
      if (!it.last_vertex) return;
      n = vert_count;
      vert_count = 0;
      if (n == 0) return;
      prev = n - 1;
      da = plane_distance(prev);
      for (int x = 0; x < n; x++) begin
         db = plane_distance(x);
         for (int j = 0; j < 8; j++) bv[j] = vstore[x][j];
         bf = db > side_tol;
         bb = db < -side_tol;
         if ((bf && da < -side_tol) || (bb && da > side_tol)) begin
            na = da < 0 ? -da : da;
            nd = (da - db) < 0 ? db - da : da - db;
            fr = (na <<< 16) / nd;
            for (int j = 0; j < 8; j++) av[j] = vstore[prev][j];
            for (int j = 0; j < 5; j++) cv[j] = av[j] + floor_q16((bv[j] - av[j]) * fr);
            for (int j = 5; j < 8; j++) cv[j] = bv[j];
            split_expected.insert(split_expected.size(), make_vertex(cv, 1'b1, 1'b1));
         end
         split_expected.insert(split_expected.size(),
                               make_vertex(bv, bf || !bb, bb || !bf));
         prev = x;
         da = db;
      end
      split_expected[$].last_of_run = 1'b1;
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on result %0d, %s: got %0h expected %0h",
               results_seen, what, got, want);
      error_count++;
   endtask

   // Driver: presents queued vertices, randomly idling.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predict_split(req_data);
            items_sent++;
         end
         if (vertex_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= vertex_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks accepted results and drives random stalls.
   always @(posedge clock) begin
      pps_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (split_expected.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.out_x, 0);
            end else begin
               want = split_expected.pop_front();
               if (rsp_data.out_x != want.out_x) report_mismatch("x", rsp_data.out_x, want.out_x);
               if (rsp_data.out_y != want.out_y) report_mismatch("y", rsp_data.out_y, want.out_y);
               if (rsp_data.out_z != want.out_z) report_mismatch("z", rsp_data.out_z, want.out_z);
               if (rsp_data.out_u != want.out_u) report_mismatch("u", rsp_data.out_u, want.out_u);
               if (rsp_data.out_v != want.out_v) report_mismatch("v", rsp_data.out_v, want.out_v);
               if (rsp_data.out_nx != want.out_nx)
                  report_mismatch("nx", rsp_data.out_nx, want.out_nx);
               if (rsp_data.out_ny != want.out_ny)
                  report_mismatch("ny", rsp_data.out_ny, want.out_ny);
               if (rsp_data.out_nz != want.out_nz)
                  report_mismatch("nz", rsp_data.out_nz, want.out_nz);
               if (rsp_data.to_front != want.to_front)
                  report_mismatch("to_front", rsp_data.to_front, want.to_front);
               if (rsp_data.to_back != want.to_back)
                  report_mismatch("to_back", rsp_data.to_back, want.to_back);
               if (rsp_data.last_of_run != want.last_of_run)
                  report_mismatch("last_of_run", rsp_data.last_of_run, want.last_of_run);
            end
            results_seen++;
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Writes one plane register and mirrors it in the software copy.
   task automatic write_reg(logic [pps_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         pps_pkg::CSR_NORMAL_X: plane_n[0] = longint'(signed'(val));
         pps_pkg::CSR_NORMAL_Y: plane_n[1] = longint'(signed'(val));
         pps_pkg::CSR_NORMAL_Z: plane_n[2] = longint'(signed'(val));
         pps_pkg::CSR_ORIGIN_X: plane_o[0] = longint'(signed'(val));
         pps_pkg::CSR_ORIGIN_Y: plane_o[1] = longint'(signed'(val));
         pps_pkg::CSR_ORIGIN_Z: plane_o[2] = longint'(signed'(val));
         pps_pkg::CSR_SIDE_TOL: side_tol = longint'(val[30:0]);
         pps_pkg::CSR_ATTR:     attr_mode = val[1:0];
         default: ;
      endcase
   endtask

   task automatic write_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                              logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                              logic [31:0] tol, logic [1:0] am);
      write_reg(pps_pkg::CSR_NORMAL_X, nx);
      write_reg(pps_pkg::CSR_NORMAL_Y, ny);
      write_reg(pps_pkg::CSR_NORMAL_Z, nz);
      write_reg(pps_pkg::CSR_ORIGIN_X, ox);
      write_reg(pps_pkg::CSR_ORIGIN_Y, oy);
      write_reg(pps_pkg::CSR_ORIGIN_Z, oz);
      write_reg(pps_pkg::CSR_SIDE_TOL, tol);
      write_reg(pps_pkg::CSR_ATTR, {30'd0, am});
   endtask

   // Mostly modest coordinates, sometimes full range.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(9))
         0: return $urandom();
         1: return ($urandom_range(1) ? 32'h7fffffff : 32'h80000000);
         default: return 32'(int'($urandom_range(40 << 16)) - (20 << 16));
      endcase
   endfunction

   function automatic pps_pkg::req_type rand_vertex(bit last);
      pps_pkg::req_type v;
      v.pos_x = rand_coord();
      v.pos_y = rand_coord();
      v.pos_z = rand_coord();
      v.tex_u = $urandom();
      v.tex_v = $urandom();
      v.norm_x = $urandom();
      v.norm_y = $urandom();
      v.norm_z = $urandom();
      v.last_vertex = last;
      return v;
   endfunction

   function automatic pps_pkg::req_type make_pos(int x, int y, int z, bit last);
      pps_pkg::req_type v;
      v = rand_vertex(last);
      v.pos_x = x;
      v.pos_y = y;
      v.pos_z = z;
      return v;
   endfunction

   // Appends one vertex to the pending items.
   task automatic queue_vertex(pps_pkg::req_type v);
      vertex_queue.insert(vertex_queue.size(), v);
   endtask

   // Waits until every queued vertex is taken and every result has come.
   task automatic drain();
      while (vertex_queue.size() > 0 || req_valid || split_expected.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic queue_polygons(int count);
      int nv;
      for (int p = 0; p < count; p++) begin
         nv = ($urandom_range(19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
         for (int i = 0; i < nv; i++) queue_vertex(rand_vertex(i == nv - 1));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = pps_pkg::CSR_NORMAL_X;
      csr_wr_data = '0;
      plane_n[0] = 65536; plane_n[1] = 0; plane_n[2] = 0;
      plane_o[0] = 0; plane_o[1] = 0; plane_o[2] = 0;
      side_tol = 66;
      attr_mode = 2'd0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset plane, triangle across x = 0, coincident vertex,
      // a single vertex, a two-vertex polygon and an overflowing store.
      queue_vertex(make_pos(-(1 << 16), 0, 0, 0));
      queue_vertex(make_pos(3 << 16, 1 << 16, 0, 0));
      queue_vertex(make_pos(0, 2 << 16, 0, 1));
      queue_vertex(make_pos(50, 0, 0, 1));
      queue_vertex(make_pos(32'h7fffffff, 0, 0, 0));
      queue_vertex(make_pos(32'h80000000, 0, 0, 1));
      for (int i = 0; i < 18; i++)
         queue_vertex(make_pos((i % 3 - 1) << 18, i << 16, 0, i == 17));
      drain();

      // Attributes on, tilted plane, zero band.
      write_plane(32'h0000b505, 32'hffff4afb, 32'h00010000, 32'h00020000,
                  32'hfffe0000, 32'h0, 32'd0, 2'd3);
      queue_polygons(12);
      drain();

      // Each idling phase with new plane settings: random ones, or fixed extremes.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? 87 : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? 87 : 0;
         if (ph == 3) begin
            send_idle_pct = 31;
            recv_stall_pct = 31;
         end
         if (ph == 2)
            write_plane(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 2'd1);
         else
            write_plane($urandom_range(1) ? $urandom() : 32'h00010000,
                        32'(int'($urandom_range(131072)) - 65536),
                        32'(int'($urandom_range(131072)) - 65536),
                        rand_coord(), rand_coord(), rand_coord(),
                        $urandom_range(1) ? $urandom_range(2000) : $urandom(),
                        2'(ph));
         queue_polygons(9);
         drain();
      end

      $display("Sent %0d vertex items and checked %0d split results", items_sent, results_seen);
      $display("over six plane settings and four idling phases.");
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Timeout guard.
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
